FILE: hdl/ps2a_pkg.sv
package ps2a_pkg;

    // selector codes carried in s_tuser
    localparam logic FUNC_SCAN = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // set-1 modifier and special scancodes
    localparam logic [7:0] SC_SHIFT_L     = 8'h2A;
    localparam logic [7:0] SC_SHIFT_R     = 8'h36;
    localparam logic [7:0] SC_SHIFT_L_BRK = 8'hAA;
    localparam logic [7:0] SC_SHIFT_R_BRK = 8'hB6;
    localparam logic [7:0] SC_CTRL        = 8'h1D;
    localparam logic [7:0] SC_CTRL_BRK    = 8'h9D;
    localparam logic [7:0] SC_CAPS        = 8'h3A;
    localparam logic [7:0] SC_F2          = 8'h3C;

    localparam logic [6:0] CH_NONE = 7'h00;
    localparam logic [6:0] CH_F2   = 7'h02;
    localparam logic [6:0] CASE_BIT = 7'h20;

    // character handed from the key decoder to the fifo
    typedef struct packed {
        logic       req;
        logic [6:0] ch;
    } ps2a_push_t;

    // fifo status toward the top level
    typedef struct packed {
        logic pop_ok;
        logic nonempty_after;
    } ps2a_stat_t;

    function automatic logic is_letter(input logic [6:0] ch);
        return ((ch >= 7'h61) && (ch <= 7'h7A)) || ((ch >= 7'h41) && (ch <= 7'h5A));
    endfunction

    // unshifted key map
    function automatic logic [6:0] plain_char(input logic [6:0] code);
        logic [6:0] ch;
        case (code)
            7'h01: ch = 7'h1B;
            7'h02: ch = 7'h31;
            7'h03: ch = 7'h32;
            7'h04: ch = 7'h33;
            7'h05: ch = 7'h34;
            7'h06: ch = 7'h35;
            7'h07: ch = 7'h36;
            7'h08: ch = 7'h37;
            7'h09: ch = 7'h38;
            7'h0A: ch = 7'h39;
            7'h0B: ch = 7'h30;
            7'h0C: ch = 7'h2D;
            7'h0D: ch = 7'h3D;
            7'h0E: ch = 7'h08;
            7'h0F: ch = 7'h09;
            7'h10: ch = 7'h71;
            7'h11: ch = 7'h77;
            7'h12: ch = 7'h65;
            7'h13: ch = 7'h72;
            7'h14: ch = 7'h74;
            7'h15: ch = 7'h79;
            7'h16: ch = 7'h75;
            7'h17: ch = 7'h69;
            7'h18: ch = 7'h6F;
            7'h19: ch = 7'h70;
            7'h1A: ch = 7'h5B;
            7'h1B: ch = 7'h5D;
            7'h1C: ch = 7'h0A;
            7'h1E: ch = 7'h61;
            7'h1F: ch = 7'h73;
            7'h20: ch = 7'h64;
            7'h21: ch = 7'h66;
            7'h22: ch = 7'h67;
            7'h23: ch = 7'h68;
            7'h24: ch = 7'h6A;
            7'h25: ch = 7'h6B;
            7'h26: ch = 7'h6C;
            7'h27: ch = 7'h3B;
            7'h28: ch = 7'h27;
            7'h29: ch = 7'h60;
            7'h2B: ch = 7'h5C;
            7'h2C: ch = 7'h7A;
            7'h2D: ch = 7'h78;
            7'h2E: ch = 7'h63;
            7'h2F: ch = 7'h76;
            7'h30: ch = 7'h62;
            7'h31: ch = 7'h6E;
            7'h32: ch = 7'h6D;
            7'h33: ch = 7'h2C;
            7'h34: ch = 7'h2E;
            7'h35: ch = 7'h2F;
            7'h37: ch = 7'h2A;
            7'h39: ch = 7'h20;
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

    // shifted key map: letters are the plain map in upper case
    function automatic logic [6:0] upper_char(input logic [6:0] code);
        logic [6:0] base;
        logic [6:0] ch;
        base = plain_char(code);
        case (code)
            7'h02: ch = 7'h21;
            7'h03: ch = 7'h40;
            7'h04: ch = 7'h23;
            7'h05: ch = 7'h24;
            7'h06: ch = 7'h25;
            7'h07: ch = 7'h5E;
            7'h08: ch = 7'h26;
            7'h09: ch = 7'h2A;
            7'h0A: ch = 7'h28;
            7'h0B: ch = 7'h29;
            7'h0C: ch = 7'h5F;
            7'h0D: ch = 7'h2B;
            7'h1A: ch = 7'h7B;
            7'h1B: ch = 7'h7D;
            7'h27: ch = 7'h3A;
            7'h28: ch = 7'h22;
            7'h29: ch = 7'h7E;
            7'h2B: ch = 7'h7C;
            7'h33: ch = 7'h3C;
            7'h34: ch = 7'h3E;
            7'h35: ch = 7'h3F;
            default: ch = is_letter(base) ? (base ^ CASE_BIT) : base;
        endcase
        return ch;
    endfunction

endpackage

FILE: hdl/ps2a_keydec.sv
module ps2a_keydec (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic [7:0]           scan_byte,
    output ps2a_pkg::ps2a_push_t push
);

    logic shift_reg, shift_next;
    logic ctrl_reg, ctrl_next;
    logic caps_reg, caps_next;
    logic [6:0] map_ch;
    logic [6:0] caps_ch;
    logic [6:0] out_ch;
    logic       is_make_key;

    // modifier decode
    always_comb begin
        shift_next  = shift_reg;
        ctrl_next   = ctrl_reg;
        caps_next   = caps_reg;
        is_make_key = 1'b0;
        unique case (scan_byte) inside
            ps2a_pkg::SC_SHIFT_L, ps2a_pkg::SC_SHIFT_R:         shift_next = 1'b1;
            ps2a_pkg::SC_SHIFT_L_BRK, ps2a_pkg::SC_SHIFT_R_BRK: shift_next = 1'b0;
            ps2a_pkg::SC_CTRL:                                  ctrl_next  = 1'b1;
            ps2a_pkg::SC_CTRL_BRK:                              ctrl_next  = 1'b0;
            ps2a_pkg::SC_CAPS:                                  caps_next  = ~caps_reg;
            default: is_make_key = ~scan_byte[7];
        endcase
    end

    // translation through the key maps, then caps lock and ctrl
    always_comb begin
        if (scan_byte == ps2a_pkg::SC_F2) begin
            map_ch = ps2a_pkg::CH_F2;
        end else if (shift_reg) begin
            map_ch = ps2a_pkg::upper_char(scan_byte[6:0]);
        end else begin
            map_ch = ps2a_pkg::plain_char(scan_byte[6:0]);
        end
        caps_ch = (caps_reg && ps2a_pkg::is_letter(map_ch)) ? (map_ch ^ ps2a_pkg::CASE_BIT)
                                                            : map_ch;
        // ctrl folds both cases of a letter onto 1..26
        out_ch = (ctrl_reg && ps2a_pkg::is_letter(caps_ch)) ? {2'b00, caps_ch[4:0]} : caps_ch;
    end

    assign push.req = en && is_make_key && (out_ch != ps2a_pkg::CH_NONE);
    assign push.ch  = out_ch;

    // modifier registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= 1'b0;
            ctrl_reg  <= 1'b0;
            caps_reg  <= 1'b0;
        end else if (en) begin
            shift_reg <= shift_next;
            ctrl_reg  <= ctrl_next;
            caps_reg  <= caps_next;
        end
    end

endmodule

FILE: hdl/ps2a_fifo.sv
module ps2a_fifo #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ps2a_pkg::ps2a_push_t push,
    input  logic                 pop_req,
    output ps2a_pkg::ps2a_stat_t stat,
    output logic [6:0]           rd_data
);

    localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

    logic [6:0]       char_mem [BUFFER_DEPTH];
    logic [6:0]       rd_data_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_inc, rd_inc;
    logic             empty, full, do_push, do_pop;

    // ring pointer arithmetic, one slot kept free
    assign wr_inc  = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_inc  = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign empty   = (wr_ptr_reg == rd_ptr_reg);
    assign full    = (wr_inc == rd_ptr_reg);
    assign do_push = push.req && !full;
    assign do_pop  = pop_req && !empty;

    assign wr_ptr_next = do_push ? wr_inc : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? rd_inc : rd_ptr_reg;

    assign stat.pop_ok         = do_pop;
    assign stat.nonempty_after = (wr_ptr_next != rd_ptr_next);
    assign rd_data             = rd_data_reg;

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // character memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (do_push) begin
            char_mem[wr_ptr_reg] <= push.ch;
        end
        if (do_pop) begin
            rd_data_reg <= char_mem[rd_ptr_reg];
        end
    end

    a_wr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ptr_reg <= PTR_LAST) else $error("write pointer out of range");
    a_rd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_ptr_reg <= PTR_LAST) else $error("read pointer out of range");
    a_push_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(do_push && pop_req)) else $error("push and pop in one word");
    a_pop_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop |=> (rd_ptr_reg != $past(rd_ptr_reg)) && $stable(wr_ptr_reg))
        else $error("pop did not advance read pointer alone");

endmodule

FILE: hdl/ps2_set1_scancode_to_ascii_fifo_unit.sv
// a result word passes stage one and the output register once its input word is accepted
// one word per cycle unless m_tready stalls; each makes at most one character memory access
// s_tready stays high while the output register drains or is empty
// reset (aresetn low, synchronous) clears shift, ctrl, caps lock, both pointers and all valids
// the character memory is not cleared; only entries already written are ever read
module ps2_set1_scancode_to_ascii_fifo_unit #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] scan_byte
    input  logic [0:0] s_tuser,   // [0] func
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] ascii, [7] has_key
    output logic [0:0] m_tuser    // [0] char_valid
);

    ps2a_pkg::ps2a_push_t push;
    ps2a_pkg::ps2a_stat_t stat;
    logic [6:0] rd_data;
    logic       accept, is_scan, is_read, s1_move;

    logic       s1_valid_reg, s1_valid_next;
    logic       s1_cv_reg, s1_hk_reg;
    logic       out_valid_reg, out_valid_next;
    logic [6:0] out_ascii_reg;
    logic       out_cv_reg, out_hk_reg;

    // handshake: stage one advances whenever the output register frees up
    assign s1_move  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_move;
    assign accept   = s_tvalid && s_tready;
    assign is_scan  = (s_tuser[0] == ps2a_pkg::FUNC_SCAN);
    assign is_read  = (s_tuser[0] == ps2a_pkg::FUNC_READ);

    ps2a_keydec u_keydec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (accept && is_scan),
        .scan_byte (s_tdata),
        .push      (push)
    );

    ps2a_fifo #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop_req (accept && is_read),
        .stat    (stat),
        .rd_data (rd_data)
    );

    assign s1_valid_next  = accept || (s1_valid_reg && !s1_move);
    assign out_valid_next = (s1_valid_reg && s1_move) || (out_valid_reg && !m_tready);

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage one flags wait for the memory read word
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cv_reg <= stat.pop_ok;
            s1_hk_reg <= stat.nonempty_after;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_move) begin
            out_ascii_reg <= s1_cv_reg ? rd_data : ps2a_pkg::CH_NONE;
            out_cv_reg    <= s1_cv_reg;
            out_hk_reg    <= s1_hk_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_hk_reg, out_ascii_reg};
    assign m_tuser[0] = out_cv_reg;

    a_no_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_move) |-> !s_tready) else $error("stage one overrun");
    a_cv_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[6:0] != ps2a_pkg::CH_NONE))
        else $error("popped character is zero");
    a_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[6:0] == ps2a_pkg::CH_NONE))
        else $error("character without char_valid");
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_read && !stat.pop_ok) |-> !stat.nonempty_after)
        else $error("failed pop on a non-empty buffer");

endmodule

FILE: bench/tb_top.sv
module tb_top;

    localparam int RING_DEPTH    = 256;
    localparam int RING_CAPACITY = RING_DEPTH - 1;
    localparam int RANDOM_WORDS  = 1600;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 300;

    // one result word as the block reports it
    typedef struct packed {
        logic [6:0] ascii;
        logic       char_valid;
        logic       has_key;
    } out_t;

    // one row of the directed script
    typedef struct packed {
        logic       func;
        logic [7:0] code;
        logic       typed;
        out_t       want;
    } script_row_t;

    localparam out_t BLANK_WORD = '{ps2a_pkg::CH_NONE, 1'b0, 1'b0};

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [0:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;

    // keyboard state as the block should hold it
    logic       shift_on;
    logic       ctrl_on;
    logic       caps_active;
    logic [6:0] typed_chars [$];

    // result words still owed by the block, oldest first
    out_t due_words [$];

    int error_count   = 0;
    int cycle_count   = 0;
    int words_sent    = 0;
    int scan_words    = 0;
    int read_words    = 0;
    int popped_chars  = 0;
    int dropped_chars = 0;
    int burst_left    = 0;

    ps2_set1_scancode_to_ascii_fifo_unit #(
        .BUFFER_DEPTH(RING_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // set-1 make code to character, plain and shifted
    function automatic logic [6:0] key_char(input logic [6:0] code, input logic shifted);
        logic [7:0] lo;
        logic [7:0] hi;
        {lo, hi} = 16'h0000;
        case (code)
            7'h01: {lo, hi} = {8'd27, 8'd27};
            7'h02: {lo, hi} = {"1", "!"};
            7'h03: {lo, hi} = {"2", "@"};
            7'h04: {lo, hi} = {"3", "#"};
            7'h05: {lo, hi} = {"4", "$"};
            7'h06: {lo, hi} = {"5", "%"};
            7'h07: {lo, hi} = {"6", "^"};
            7'h08: {lo, hi} = {"7", "&"};
            7'h09: {lo, hi} = {"8", "*"};
            7'h0A: {lo, hi} = {"9", "("};
            7'h0B: {lo, hi} = {"0", ")"};
            7'h0C: {lo, hi} = {"-", "_"};
            7'h0D: {lo, hi} = {"=", "+"};
            7'h0E: {lo, hi} = {8'd8, 8'd8};
            7'h0F: {lo, hi} = {8'd9, 8'd9};
            7'h10: {lo, hi} = {"q", "Q"};
            7'h11: {lo, hi} = {"w", "W"};
            7'h12: {lo, hi} = {"e", "E"};
            7'h13: {lo, hi} = {"r", "R"};
            7'h14: {lo, hi} = {"t", "T"};
            7'h15: {lo, hi} = {"y", "Y"};
            7'h16: {lo, hi} = {"u", "U"};
            7'h17: {lo, hi} = {"i", "I"};
            7'h18: {lo, hi} = {"o", "O"};
            7'h19: {lo, hi} = {"p", "P"};
            7'h1A: {lo, hi} = {"[", "{"};
            7'h1B: {lo, hi} = {"]", "}"};
            7'h1C: {lo, hi} = {8'd10, 8'd10};
            7'h1E: {lo, hi} = {"a", "A"};
            7'h1F: {lo, hi} = {"s", "S"};
            7'h20: {lo, hi} = {"d", "D"};
            7'h21: {lo, hi} = {"f", "F"};
            7'h22: {lo, hi} = {"g", "G"};
            7'h23: {lo, hi} = {"h", "H"};
            7'h24: {lo, hi} = {"j", "J"};
            7'h25: {lo, hi} = {"k", "K"};
            7'h26: {lo, hi} = {"l", "L"};
            7'h27: {lo, hi} = {";", ":"};
            7'h28: {lo, hi} = {"'", "\""};
            7'h29: {lo, hi} = {8'h60, "~"};
            7'h2B: {lo, hi} = {"\\", "|"};
            7'h2C: {lo, hi} = {"z", "Z"};
            7'h2D: {lo, hi} = {"x", "X"};
            7'h2E: {lo, hi} = {"c", "C"};
            7'h2F: {lo, hi} = {"v", "V"};
            7'h30: {lo, hi} = {"b", "B"};
            7'h31: {lo, hi} = {"n", "N"};
            7'h32: {lo, hi} = {"m", "M"};
            7'h33: {lo, hi} = {",", "<"};
            7'h34: {lo, hi} = {".", ">"};
            7'h35: {lo, hi} = {"/", "?"};
            7'h37: {lo, hi} = {"*", "*"};
            7'h39: {lo, hi} = {" ", " "};
            default: {lo, hi} = 16'h0000;
        endcase
        return shifted ? hi[6:0] : lo[6:0];
    endfunction

    // advance the keyboard state by one accepted word and work out its result
    task automatic translate_word(input logic func, input logic [7:0] code, output out_t res);
        logic [6:0] ch;
        res = BLANK_WORD;
        ch  = ps2a_pkg::CH_NONE;
        if (func == ps2a_pkg::FUNC_SCAN) begin
            scan_words++;
            if (code == ps2a_pkg::SC_SHIFT_L || code == ps2a_pkg::SC_SHIFT_R) begin
                shift_on = 1'b1;
            end else if (code == ps2a_pkg::SC_SHIFT_L_BRK || code == ps2a_pkg::SC_SHIFT_R_BRK) begin
                shift_on = 1'b0;
            end else if (code == ps2a_pkg::SC_CTRL) begin
                ctrl_on = 1'b1;
            end else if (code == ps2a_pkg::SC_CTRL_BRK) begin
                ctrl_on = 1'b0;
            end else if (code == ps2a_pkg::SC_CAPS) begin
                caps_active = !caps_active;
            end else if (!code[7]) begin
                ch = (code == ps2a_pkg::SC_F2) ? ps2a_pkg::CH_F2 : key_char(code[6:0], shift_on);
                // caps lock flips letter case
                if (caps_active) begin
                    if (ch >= "a" && ch <= "z") begin
                        ch = ch - ps2a_pkg::CASE_BIT;
                    end else if (ch >= "A" && ch <= "Z") begin
                        ch = ch + ps2a_pkg::CASE_BIT;
                    end
                end
                // ctrl turns letters into 1..26
                if (ctrl_on) begin
                    if (ch >= "a" && ch <= "z") begin
                        ch = ch - 7'h60;
                    end else if (ch >= "A" && ch <= "Z") begin
                        ch = ch - 7'h40;
                    end
                end
                if (ch != ps2a_pkg::CH_NONE) begin
                    if (typed_chars.size() < RING_CAPACITY) begin
                        typed_chars.push_back(ch);
                    end else begin
                        dropped_chars++;
                    end
                end
            end
        end else begin
            read_words++;
            if (typed_chars.size() != 0) begin
                res.ascii      = typed_chars.pop_front();
                res.char_valid = 1'b1;
                popped_chars++;
            end
        end
        res.has_key = (typed_chars.size() != 0);
    endtask

    // offer one word, wait for the handshake, then maybe idle between bursts
    task automatic send_word(input logic func, input logic [7:0] code,
                             input logic typed, input out_t want);
        out_t res;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= code;
        do @(posedge aclk); while (!s_tready);
        translate_word(func, code, res);
        due_words.push_back(typed ? want : res);
        words_sent++;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end else begin
            burst_left--;
        end
    endtask

    // receiver: changing stall patterns, plus one long hold while words keep coming
    logic [7:0] stall_phase = 8'd0;
    logic [1:0] stall_mode  = 2'd0;
    int         hold_left   = 0;
    logic       hold_done   = 1'b0;

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && words_sent >= 400) begin
            m_tready  <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            stall_phase <= stall_phase + 8'd1;
            if (stall_phase == 8'd0) begin
                stall_mode <= 2'($urandom_range(0, 3));
            end
            case (stall_mode)
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= 1'($urandom_range(0, 1));
                2'd2: m_tready <= (stall_phase[2:0] != 3'd0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // compare each result word with the oldest one owed
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_words.size() == 0) begin
                error_count++;
                $display("%0t: result word with nothing expected: ascii %h",
                         $time, m_tdata[6:0]);
                $display("%0t: char_valid %b has_key %b", $time, m_tuser[0], m_tdata[7]);
            end else begin
                want = due_words.pop_front();
                if (m_tdata[6:0] !== want.ascii) begin
                    error_count++;
                    $display("%0t: ascii expected %h actual %h", $time, want.ascii, m_tdata[6:0]);
                end
                if (m_tuser[0] !== want.char_valid) begin
                    error_count++;
                    $display("%0t: char_valid expected %b actual %b",
                             $time, want.char_valid, m_tuser[0]);
                end
                if (m_tdata[7] !== want.has_key) begin
                    error_count++;
                    $display("%0t: has_key expected %b actual %b",
                             $time, want.has_key, m_tdata[7]);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d result words outstanding", $time, due_words.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stimulus
    initial begin
        script_row_t script [$];
        int          pick;
        int          n;
        logic        func;
        logic [7:0]  code;

        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tuser     = ps2a_pkg::FUNC_SCAN;
        shift_on    = 1'b0;
        ctrl_on     = 1'b0;
        caps_active = 1'b0;

        // directed part: empty read, unmapped and ignored codes, modifiers, F2, edges
        script = '{
            '{ps2a_pkg::FUNC_READ, 8'h00, 1'b1, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, 8'h00, 1'b1, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, 8'h7F, 1'b1, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, 8'hFF, 1'b1, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, 8'h80, 1'b1, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, 8'h1E, 1'b1, '{ps2a_pkg::CH_NONE, 1'b0, 1'b1}},
            '{ps2a_pkg::FUNC_READ, 8'hFF, 1'b1, '{7'h61, 1'b1, 1'b0}},
            '{ps2a_pkg::FUNC_SCAN, ps2a_pkg::SC_SHIFT_L, 1'b1, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, 8'h1E, 1'b0, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, 8'h02, 1'b0, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, ps2a_pkg::SC_SHIFT_L_BRK, 1'b0, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, ps2a_pkg::SC_SHIFT_R, 1'b0, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, 8'h35, 1'b0, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, ps2a_pkg::SC_SHIFT_R_BRK, 1'b0, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, ps2a_pkg::SC_CAPS, 1'b0, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, 8'h10, 1'b0, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, ps2a_pkg::SC_CTRL, 1'b0, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, 8'h1E, 1'b0, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, ps2a_pkg::SC_F2, 1'b0, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, ps2a_pkg::SC_CTRL_BRK, 1'b0, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, ps2a_pkg::SC_CAPS, 1'b0, BLANK_WORD},
            '{ps2a_pkg::FUNC_SCAN, 8'h01, 1'b0, BLANK_WORD},
            '{ps2a_pkg::FUNC_READ, 8'hAA, 1'b0, BLANK_WORD},
            '{ps2a_pkg::FUNC_READ, 8'h55, 1'b0, BLANK_WORD},
            '{ps2a_pkg::FUNC_READ, 8'h00, 1'b0, BLANK_WORD}
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            send_word(script[i].func, script[i].code, script[i].typed, script[i].want);
        end

        // fill the ring past capacity, then drain it and read on empty
        repeat (RING_DEPTH + 20)
            send_word(ps2a_pkg::FUNC_SCAN, 8'($urandom_range(8'h10, 8'h19)), 1'b0, BLANK_WORD);
        repeat (RING_DEPTH + 4)
            send_word(ps2a_pkg::FUNC_READ, 8'($urandom_range(0, 255)), 1'b0, BLANK_WORD);

        // random part: typing bursts with modifiers and noise, read bursts, refills
        while (words_sent < RANDOM_WORDS + script.size()) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                repeat (RING_DEPTH + 10)
                    send_word(ps2a_pkg::FUNC_SCAN, 8'($urandom_range(1, 8'h39)),
                              1'b0, BLANK_WORD);
            end else if (pick < 8) begin
                repeat (RING_DEPTH + 4)
                    send_word(ps2a_pkg::FUNC_READ, 8'($urandom_range(0, 255)),
                              1'b0, BLANK_WORD);
            end else if (pick < 35) begin
                repeat ($urandom_range(1, 30))
                    send_word(ps2a_pkg::FUNC_READ, 8'($urandom_range(0, 255)),
                              1'b0, BLANK_WORD);
            end else begin
                n = $urandom_range(4, 40);
                repeat (n) begin
                    pick = $urandom_range(0, 99);
                    func = ps2a_pkg::FUNC_SCAN;
                    code = 8'($urandom_range(0, 255));
                    if (pick < 55) begin
                        code = 8'($urandom_range(1, 8'h39));
                    end else if (pick < 65) begin
                        code[7] = 1'b0;
                    end else if (pick < 78) begin
                        case ($urandom_range(0, 7))
                            0: code = ps2a_pkg::SC_SHIFT_L;
                            1: code = ps2a_pkg::SC_SHIFT_R;
                            2: code = ps2a_pkg::SC_SHIFT_L_BRK;
                            3: code = ps2a_pkg::SC_SHIFT_R_BRK;
                            4: code = ps2a_pkg::SC_CTRL;
                            5: code = ps2a_pkg::SC_CTRL_BRK;
                            6: code = ps2a_pkg::SC_CAPS;
                            default: code = ps2a_pkg::SC_F2;
                        endcase
                    end else if (pick >= 83) begin
                        func = ps2a_pkg::FUNC_READ;
                    end
                    send_word(func, code, 1'b0, BLANK_WORD);
                end
            end
        end

        // let every owed word come out, then keep watching the output for strays
        s_tvalid <= 1'b0;
        while (due_words.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("run covered %0d words: %0d scancodes, %0d reads", words_sent, scan_words,
                 read_words);
        $display("%0d characters popped, %0d dropped on a full ring, %0d cycles",
                 popped_chars, dropped_chars, cycle_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/ps2a_pkg.sv
hdl/ps2a_keydec.sv
hdl/ps2a_fifo.sv
hdl/ps2_set1_scancode_to_ascii_fifo_unit.sv
bench/tb_top.sv
